// ===== sv/hidfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID fieldbus report handler package
// Sizes, protocol byte codes, register indexes and the command record that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package hidfb_pkg;

   // Report geometry.
   localparam int REPORT_BYTES = 64;
   localparam int ADDR_W       = $clog2(REPORT_BYTES);
   localparam int CNT_W        = $clog2(REPORT_BYTES + 1);
   localparam int BODY_START   = 11;
   localparam int BODY_MAX     = REPORT_BYTES - BODY_START;
   localparam int HDR_BYTES    = 14;
   localparam int BANKS        = 2;
   localparam int BUSY_W       = $clog2(BANKS + 1);

   // Command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Byte positions inside a report.
   localparam int IDX_REPORT_ID   = 0;
   localparam int IDX_PACKET_INFO = 1;
   localparam int IDX_DATA_LEN    = 2;
   localparam int IDX_VERSION     = 3;
   localparam int IDX_HDR_LEN     = 4;
   localparam int IDX_BODY_LEN_HI = 5;
   localparam int IDX_BODY_LEN_LO = 6;
   localparam int IDX_PROTOCOL    = 7;
   localparam int IDX_SERVICE     = 8;
   localparam int IDX_FEATURE     = 11;
   localparam int IDX_FEAT_HI     = 12;
   localparam int IDX_FEAT_LO     = 13;

   // Header codes.
   localparam logic [7:0] REPORT_ID_OUT    = 8'h01;
   localparam logic [7:0] PACKET_INFO_ONE  = 8'h13;
   localparam logic [7:0] PROTOCOL_VERSION = 8'h00;
   localparam logic [7:0] HEADER_LENGTH    = 8'h08;
   localparam logic [7:0] PROTO_BUS_ACCESS = 8'h0F;
   localparam logic [7:0] PROTO_TUNNEL     = 8'h01;
   localparam logic [7:0] EMI_CEMI         = 8'h03;
   localparam logic [7:0] SVC_FEATURE_GET  = 8'h01;
   localparam logic [7:0] SVC_FEATURE_RESP = 8'h02;
   localparam logic [7:0] PLEN_EXTRA       = 8'h03;

   // Feature identifiers and fixed answers.
   localparam logic [7:0] FEAT_EMI_TYPES   = 8'h01;
   localparam logic [7:0] FEAT_MASK_VER    = 8'h02;
   localparam logic [7:0] FEAT_BUS_STATUS  = 8'h03;
   localparam logic [7:0] FEAT_MANUF_CODE  = 8'h04;
   localparam logic [7:0] FEAT_ACTIVE_EMI  = 8'h05;
   localparam logic [7:0] EMI_TYPES_HI     = 8'h00;
   localparam logic [7:0] EMI_TYPES_LO     = 8'h04;
   localparam logic [7:0] BUS_STATUS_ON    = 8'h01;
   localparam logic [7:0] ACTIVE_EMI_CEMI  = 8'h03;

   // Configuration register indexes.
   localparam int               CSR_INDEX_W           = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUFACTURER_CODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_VERSION      = 1'd1;

   // Output run kinds.
   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_TUNNEL   = 1'b1;

   typedef struct packed {
      logic              kind;
      logic              bank;
      logic [CNT_W-1:0]  len;
      logic [ADDR_W-1:0] start;
      logic [CNT_W-1:0]  plen;
      logic              size2;
      logic [7:0]        b2_adj;
      logic [7:0]        b6_adj;
      logic [7:0]        data_hi;
      logic [7:0]        data_lo;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_READ,
      BACK_EMIT
   } back_state_type;

endpackage

// ===== sv/hid_fieldbus_report_handler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID fieldbus report handler
// Receives HID OUT reports byte by byte, answers bus-access feature-get
// requests and forwards the bodies of tunneled cEMI frames.
// ----------------------------------------------------------------------------
// Usage:
// The req_ stream carries one report byte per transaction, with tlast on the
// final byte. Only reports of exactly 64 bytes are considered; others are
// silently dropped. The rsp_ stream returns either a 64-byte response report
// (tuser 0) or the body bytes of a tunneled frame (tuser 1), tlast on the
// final byte of each run. The csr_ port writes the manufacturer code (index
// 0) and the mask version (index 1); it is always ready and must only be
// written while the block is idle.
// Throughput: the input takes one byte per cycle while req_tready is high.
// For each output byte the back end first addresses the buffer RAM in
// BACK_READ and then loads the output register in BACK_EMIT. With the back
// end idle, the command for a completed report goes through the command
// queue and the BACK_IDLE, BACK_READ and BACK_EMIT states before rsp_tvalid rises.
// Two buffer banks let the next report stream in while the previous one is
// drained; req_tready falls only when both banks hold pending reports.
// A stalled receiver holds the output register and the back end waits; the
// input keeps running until both banks are taken. Reset empties the command
// queue, clears the byte count and sets both registers to zero. No clearing
// pass is needed.
// ----------------------------------------------------------------------------
module hid_fieldbus_report_handler (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input stream; tdata: in_byte[7:0]. tlast: in_last.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  req_tlast,
   // Output stream; tdata: out_byte[7:0]. tuser: out_kind[0]. tlast: out_last.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,
   output logic [0:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hidfb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                           csr_data
);

   logic [15:0] manufacturer_code_ff, manufacturer_code_in;
   logic [15:0] mask_version_ff, mask_version_in;

   logic                       wr_en;
   logic [hidfb_pkg::ADDR_W:0] wr_addr;
   logic [7:0]                 wr_data;
   logic                       rd_en;
   logic [hidfb_pkg::ADDR_W:0] rd_addr;
   logic [7:0]                 rd_data;
   logic                       push;
   hidfb_pkg::cmd_type         push_cmd;
   logic                       pop;
   logic                       cmd_valid;
   hidfb_pkg::cmd_type         cmd;
   logic                       release_bank;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   always_comb begin
      manufacturer_code_in = manufacturer_code_ff;
      mask_version_in      = mask_version_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hidfb_pkg::CSR_MANUFACTURER_CODE: manufacturer_code_in = csr_data;
            hidfb_pkg::CSR_MASK_VERSION:      mask_version_in      = csr_data;
            default: begin
               manufacturer_code_in = manufacturer_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manufacturer_code_ff <= 16'h0000;
         mask_version_ff      <= 16'h0000;
      end else begin
         manufacturer_code_ff <= manufacturer_code_in;
         mask_version_ff      <= mask_version_in;
      end
   end

   // Two banks of one report each; the bank bit is the top address bit.
   hidfb_ram #(
      .WIDTH (8),
      .DEPTH (hidfb_pkg::BANKS * hidfb_pkg::REPORT_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hidfb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .manufacturer_code (manufacturer_code_ff),
      .mask_version      (mask_version_ff),
      .release_bank      (release_bank),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   hidfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   hidfb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .pop          (pop),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .release_bank (release_bank),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== sv/hidfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hidfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hidfb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID fieldbus front end
// Stores report bytes into the current buffer bank, captures the header and
// classifies a complete report into a command for the back end.
// ----------------------------------------------------------------------------
module hidfb_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tlast,
   input  logic [15:0]                      manufacturer_code,
   input  logic [15:0]                      mask_version,
   input  logic                             release_bank,
   output logic                             wr_en,
   output logic [hidfb_pkg::ADDR_W:0]       wr_addr,
   output logic [7:0]                       wr_data,
   output logic                             push,
   output hidfb_pkg::cmd_type               push_cmd
);

   logic [hidfb_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                         overflow_ff, overflow_in;
   logic                         bank_ff, bank_in;
   logic [hidfb_pkg::BUSY_W-1:0] busy_ff, busy_in;
   logic [7:0]                   hdr_ff [hidfb_pkg::HDR_BYTES];

   logic       accept;
   logic       complete;
   logic       hdr_ok;
   logic [8:0] plen9;
   logic       feat_valid;
   logic       tun_valid;
   logic [1:0] feat_size;
   logic [7:0] feat_hi;
   logic [7:0] feat_lo;
   logic [15:0] body_len;
   logic [7:0] b6_base;

   assign req_tready = (busy_ff != hidfb_pkg::BUSY_W'(hidfb_pkg::BANKS));
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (count_ff < hidfb_pkg::CNT_W'(hidfb_pkg::REPORT_BYTES));
   assign wr_addr    = {bank_ff, count_ff[hidfb_pkg::ADDR_W-1:0]};
   assign wr_data    = req_tdata;

   // The last byte of a well-sized report lands at the final position.
   assign complete = accept && req_tlast && !overflow_ff &&
                     (count_ff == hidfb_pkg::CNT_W'(hidfb_pkg::REPORT_BYTES - 1));

   always_comb begin
      hdr_ok = (hdr_ff[hidfb_pkg::IDX_REPORT_ID] == hidfb_pkg::REPORT_ID_OUT) &&
               (hdr_ff[hidfb_pkg::IDX_PACKET_INFO] == hidfb_pkg::PACKET_INFO_ONE) &&
               (hdr_ff[hidfb_pkg::IDX_VERSION] == hidfb_pkg::PROTOCOL_VERSION) &&
               (hdr_ff[hidfb_pkg::IDX_HDR_LEN] == hidfb_pkg::HEADER_LENGTH);
      plen9 = {1'b0, hdr_ff[hidfb_pkg::IDX_DATA_LEN]} + {1'b0, hidfb_pkg::PLEN_EXTRA};

      feat_size = 2'd0;
      feat_hi   = 8'h00;
      feat_lo   = 8'h00;
      case (hdr_ff[hidfb_pkg::IDX_FEATURE])
         hidfb_pkg::FEAT_EMI_TYPES: begin
            feat_size = 2'd2;
            feat_hi   = hidfb_pkg::EMI_TYPES_HI;
            feat_lo   = hidfb_pkg::EMI_TYPES_LO;
         end
         hidfb_pkg::FEAT_MASK_VER: begin
            feat_size = 2'd2;
            feat_hi   = mask_version[15:8];
            feat_lo   = mask_version[7:0];
         end
         hidfb_pkg::FEAT_BUS_STATUS: begin
            feat_size = 2'd1;
            feat_hi   = hidfb_pkg::BUS_STATUS_ON;
         end
         hidfb_pkg::FEAT_MANUF_CODE: begin
            feat_size = 2'd2;
            feat_hi   = manufacturer_code[15:8];
            feat_lo   = manufacturer_code[7:0];
         end
         hidfb_pkg::FEAT_ACTIVE_EMI: begin
            feat_size = 2'd1;
            feat_hi   = hidfb_pkg::ACTIVE_EMI_CEMI;
         end
         default: begin
            feat_size = 2'd0;
         end
      endcase

      feat_valid = hdr_ok &&
                   (hdr_ff[hidfb_pkg::IDX_PROTOCOL] == hidfb_pkg::PROTO_BUS_ACCESS) &&
                   (plen9 <= 9'(hidfb_pkg::REPORT_BYTES)) &&
                   (hdr_ff[hidfb_pkg::IDX_SERVICE] == hidfb_pkg::SVC_FEATURE_GET) &&
                   (feat_size != 2'd0);

      body_len  = {hdr_ff[hidfb_pkg::IDX_BODY_LEN_HI], hdr_ff[hidfb_pkg::IDX_BODY_LEN_LO]};
      tun_valid = hdr_ok &&
                  (hdr_ff[hidfb_pkg::IDX_PROTOCOL] == hidfb_pkg::PROTO_TUNNEL) &&
                  (hdr_ff[hidfb_pkg::IDX_SERVICE] == hidfb_pkg::EMI_CEMI) &&
                  (body_len <= 16'(hidfb_pkg::BODY_MAX)) &&
                  (body_len != 16'd0);

      // Byte 6 lies past the packet when the packet is shorter than seven bytes.
      b6_base = (plen9 > 9'(hidfb_pkg::IDX_BODY_LEN_LO)) ?
                hdr_ff[hidfb_pkg::IDX_BODY_LEN_LO] : 8'h00;

      push_cmd.bank    = bank_ff;
      push_cmd.plen    = hidfb_pkg::CNT_W'(plen9);
      push_cmd.size2   = (feat_size == 2'd2);
      push_cmd.b2_adj  = hdr_ff[hidfb_pkg::IDX_DATA_LEN] + {6'd0, feat_size};
      push_cmd.b6_adj  = b6_base + {6'd0, feat_size};
      push_cmd.data_hi = feat_hi;
      push_cmd.data_lo = feat_lo;
      if (feat_valid) begin
         push_cmd.kind  = hidfb_pkg::KIND_RESPONSE;
         push_cmd.len   = hidfb_pkg::CNT_W'(hidfb_pkg::REPORT_BYTES);
         push_cmd.start = hidfb_pkg::ADDR_W'(0);
      end else begin
         push_cmd.kind  = hidfb_pkg::KIND_TUNNEL;
         push_cmd.len   = hidfb_pkg::CNT_W'(body_len);
         push_cmd.start = hidfb_pkg::ADDR_W'(hidfb_pkg::BODY_START);
      end
   end

   assign push = complete && (feat_valid || tun_valid);

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      bank_in     = bank_ff;
      if (accept) begin
         if (wr_en) begin
            count_in = count_ff + hidfb_pkg::CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
         if (req_tlast) begin
            count_in    = '0;
            overflow_in = 1'b0;
         end
      end
      if (push) begin
         bank_in = ~bank_ff;
      end
      busy_in = busy_ff;
      if (push && !release_bank) begin
         busy_in = busy_ff + hidfb_pkg::BUSY_W'(1);
      end else if (!push && release_bank) begin
         busy_in = busy_ff - hidfb_pkg::BUSY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         bank_ff     <= 1'b0;
         busy_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         bank_ff     <= bank_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < hidfb_pkg::HDR_BYTES; k++) begin
         if (accept && (count_ff == hidfb_pkg::CNT_W'(k))) begin
            hdr_ff[k] <= req_tdata;
         end
      end
   end

endmodule

// ===== sv/hidfb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID fieldbus command queue
// Short first-in first-out queue of commands from front end to back end.
// ----------------------------------------------------------------------------
module hidfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hidfb_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               cmd_valid,
   output hidfb_pkg::cmd_type cmd
);

   hidfb_pkg::cmd_type            entry_ff [hidfb_pkg::QUEUE_DEPTH];
   logic [hidfb_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hidfb_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hidfb_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_push   = push && (count_ff != hidfb_pkg::QCNT_W'(hidfb_pkg::QUEUE_DEPTH));
   assign do_pop    = pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + hidfb_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + hidfb_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + hidfb_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - hidfb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/hidfb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID fieldbus back end
// Walks one buffer bank per command and streams the response or tunneled body.
// ----------------------------------------------------------------------------
module hidfb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  hidfb_pkg::cmd_type           cmd,
   output logic                         pop,
   output logic                         rd_en,
   output logic [hidfb_pkg::ADDR_W:0]   rd_addr,
   input  logic [7:0]                   rd_data,
   output logic                         release_bank,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic [0:0]                   rsp_tuser,
   output logic                         rsp_tlast
);

   hidfb_pkg::back_state_type    state_ff, state_in;
   hidfb_pkg::cmd_type           cmd_ff, cmd_in;
   logic [hidfb_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_byte_ff, out_byte_in;
   logic                         out_kind_ff, out_kind_in;
   logic                         out_last_ff, out_last_in;

   logic       is_last;
   logic       in_pkt;
   logic [7:0] resp_byte;

   assign is_last = (({1'b0, idx_ff} + hidfb_pkg::CNT_W'(1)) == cmd_ff.len);
   assign in_pkt  = ({1'b0, idx_ff} < cmd_ff.plen);

   always_comb begin
      resp_byte = in_pkt ? rd_data : 8'h00;
      if (idx_ff == hidfb_pkg::ADDR_W'(hidfb_pkg::IDX_DATA_LEN)) begin
         resp_byte = cmd_ff.b2_adj;
      end else if (idx_ff == hidfb_pkg::ADDR_W'(hidfb_pkg::IDX_BODY_LEN_LO)) begin
         resp_byte = cmd_ff.b6_adj;
      end else if (idx_ff == hidfb_pkg::ADDR_W'(hidfb_pkg::IDX_SERVICE)) begin
         resp_byte = hidfb_pkg::SVC_FEATURE_RESP;
      end else if (idx_ff == hidfb_pkg::ADDR_W'(hidfb_pkg::IDX_FEAT_HI)) begin
         resp_byte = cmd_ff.data_hi;
      end else if (idx_ff == hidfb_pkg::ADDR_W'(hidfb_pkg::IDX_FEAT_LO) && cmd_ff.size2) begin
         resp_byte = cmd_ff.data_lo;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = {cmd_ff.bank, cmd_ff.start + idx_ff};
      release_bank = 1'b0;
      case (state_ff)
         hidfb_pkg::BACK_IDLE: begin
            if (cmd_valid) begin
               pop      = 1'b1;
               cmd_in   = cmd;
               idx_in   = '0;
               state_in = hidfb_pkg::BACK_READ;
            end
         end
         hidfb_pkg::BACK_READ: begin
            rd_en    = 1'b1;
            state_in = hidfb_pkg::BACK_EMIT;
         end
         hidfb_pkg::BACK_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_kind_in  = cmd_ff.kind;
               out_last_in  = is_last;
               out_byte_in  = (cmd_ff.kind == hidfb_pkg::KIND_RESPONSE) ? resp_byte : rd_data;
               idx_in       = idx_ff + hidfb_pkg::ADDR_W'(1);
               if (is_last) begin
                  release_bank = 1'b1;
                  state_in     = hidfb_pkg::BACK_IDLE;
               end else begin
                  state_in = hidfb_pkg::BACK_READ;
               end
            end
         end
         default: begin
            state_in = hidfb_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hidfb_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/hidfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID fieldbus port checker
// Concurrent checks on the top-level ports, bound to the handler.
// ----------------------------------------------------------------------------
module hidfb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [7:0]                        rsp_tdata,
   input logic [0:0]                        rsp_tuser,
   input logic                              rsp_tlast
);

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // Input backpressure only starts when a report has just been completed.
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $fell(req_tready)) |-> $past(req_tvalid && req_tlast))
      else $error("req_tready fell without a final byte being taken");

   // An offered output byte stays offered until taken.
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // A stalled output byte keeps its payload.
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         ($stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("rsp payload changed while stalled");

endmodule

bind hid_fieldbus_report_handler hidfb_checker u_hidfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
